// File: design/bpc_pkg.sv
// Shared constants, calibration and pipeline types for the pressure compensation block.
package bpc_pkg;

	localparam int NumStages = 9;

	localparam int AddrW = 5;
	localparam int DataW = 32;
	localparam int CalW  = 16;

	localparam logic [2:0] RegPressSens = 3'd0;
	localparam logic [2:0] RegPressOff  = 3'd1;
	localparam logic [2:0] RegSensTc    = 3'd2;
	localparam logic [2:0] RegOffTc     = 3'd3;
	localparam logic [2:0] RegRefTemp   = 3'd4;
	localparam logic [2:0] RegTempCoeff = 3'd5;

	localparam int RawW   = 24;
	localparam int DtW    = 25;
	localparam int ProdW  = 42;
	localparam int DtSqW  = 50;
	localparam int AW     = 18;
	localparam int BW     = 19;
	localparam int T2W    = 17;
	localparam int OffW   = 35;
	localparam int SensW  = 34;
	localparam int SqW    = 35;
	localparam int Off2W  = 38;
	localparam int Sens2W = 37;
	localparam int OffCW  = 39;
	localparam int SensCW = 38;
	localparam int TempW  = 16;
	localparam int PressW = 18;

	localparam int ShiftTemp  = 23;
	localparam int ShiftT2    = 31;
	localparam int ShiftOff   = 7;
	localparam int ShiftSens  = 8;
	localparam int ShiftPress = 21;
	localparam int ShiftFinal = 15;
	localparam int SensSplit  = 19;

	localparam logic signed [AW-1:0] ColdLimit   = -18'sd3500;
	localparam logic signed [BW-1:0] ColdOffset  = 19'sd3500;
	localparam logic signed [19:0]   TempRef     = 20'sd2000;

	typedef logic [NumStages-1:0] stage_vec_t;

	typedef struct packed {
		logic [CalW-1:0] pressure_sensitivity;
		logic [CalW-1:0] pressure_offset;
		logic [CalW-1:0] sensitivity_temp_coeff;
		logic [CalW-1:0] offset_temp_coeff;
		logic [CalW-1:0] reference_temperature;
		logic [CalW-1:0] temperature_coeff;
	} cal_t;

	// first-order terms, leaving the front section
	typedef struct packed {
		logic [RawW-1:0]         d1;
		logic signed [AW-1:0]    a;
		logic signed [BW-1:0]    b;
		logic                    cold;
		logic                    very_cold;
		logic [T2W-1:0]          t2;
		logic signed [OffW-1:0]  off;
		logic signed [SensW-1:0] sens;
	} lin_t;

	// corrected terms, leaving the correction section
	typedef struct packed {
		logic [RawW-1:0]          d1;
		logic signed [TempW-1:0]  temp;
		logic signed [OffCW-1:0]  off_c;
		logic signed [SensCW-1:0] sens_c;
	} corr_t;

endpackage

// File: design/bpc_regs.sv
// APB register file holding the six calibration words.
module bpc_regs (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [bpc_pkg::AddrW-1:0] paddr,
	input  logic [bpc_pkg::DataW-1:0] pwdata,
	output logic [bpc_pkg::DataW-1:0] prdata,
	output bpc_pkg::cal_t             cal
);
	import bpc_pkg::*;

	cal_t       cal_q;
	logic [2:0] idx;
	logic       wr;
	logic [CalW-1:0] rd_word;

	assign idx = paddr[4:2];
	assign wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_q <= '0;
		end else if (wr) begin
			unique case (idx)
				RegPressSens: cal_q.pressure_sensitivity   <= pwdata[CalW-1:0];
				RegPressOff:  cal_q.pressure_offset        <= pwdata[CalW-1:0];
				RegSensTc:    cal_q.sensitivity_temp_coeff <= pwdata[CalW-1:0];
				RegOffTc:     cal_q.offset_temp_coeff      <= pwdata[CalW-1:0];
				RegRefTemp:   cal_q.reference_temperature  <= pwdata[CalW-1:0];
				RegTempCoeff: cal_q.temperature_coeff      <= pwdata[CalW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			RegPressSens: rd_word = cal_q.pressure_sensitivity;
			RegPressOff:  rd_word = cal_q.pressure_offset;
			RegSensTc:    rd_word = cal_q.sensitivity_temp_coeff;
			RegOffTc:     rd_word = cal_q.offset_temp_coeff;
			RegRefTemp:   rd_word = cal_q.reference_temperature;
			RegTempCoeff: rd_word = cal_q.temperature_coeff;
			default:      rd_word = '0;
		endcase
	end

	assign prdata = {{(DataW-CalW){1'b0}}, rd_word};
	assign cal    = cal_q;

endmodule

// File: design/bpc_ctrl.sv
// Valid bits and per-stage load enables of the compensation pipeline.
module bpc_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                sample_valid,
	input  logic                result_stall,
	output bpc_pkg::stage_vec_t en,
	output logic                sample_stall,
	output logic                result_valid
);
	import bpc_pkg::*;

	stage_vec_t vld_q;
	stage_vec_t vld_in;

	// a stage loads when it is empty or the one after it moves on
	always_comb begin
		en[NumStages-1] = !vld_q[NumStages-1] || !result_stall;
		for (int k = NumStages - 2; k >= 0; k--) begin
			en[k] = !vld_q[k] || en[k+1];
		end
	end

	assign vld_in = {vld_q[NumStages-2:0], sample_valid};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int k = 0; k < NumStages; k++) begin
				if (en[k]) vld_q[k] <= vld_in[k];
			end
		end
	end

	assign sample_stall = !en[0];
	assign result_valid = vld_q[NumStages-1];

endmodule

// File: design/bpc_lin.sv
// Stages 1-3: temperature difference, the four products and first-order terms.
module bpc_lin (
	input  logic                           clk,
	input  logic [2:0]                     en,
	input  bpc_pkg::cal_t                  cal,
	input  logic [bpc_pkg::RawW-1:0]       raw_pressure,
	input  logic [bpc_pkg::RawW-1:0]       raw_temperature,
	output bpc_pkg::lin_t                  lin
);
	import bpc_pkg::*;

	// stage 1
	logic [RawW-1:0]         d1_s1;
	logic signed [DtW-1:0]   dt_s1;
	// stage 2
	logic [RawW-1:0]         d1_s2;
	logic signed [ProdW-1:0] tmul_s2;
	logic signed [ProdW-1:0] omul_s2;
	logic signed [ProdW-1:0] smul_s2;
	logic signed [DtSqW-1:0] dtsq_s2;
	// stage 3
	lin_t                    lin_s3;

	logic signed [AW-1:0]    a_c;
	logic signed [OffW-1:0]  off_base;
	logic signed [SensW-1:0] sens_base;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			d1_s1 <= raw_pressure;
			dt_s1 <= $signed({1'b0, raw_temperature})
				- $signed({1'b0, cal.reference_temperature, 8'b0});
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			d1_s2   <= d1_s1;
			tmul_s2 <= dt_s1 * $signed({1'b0, cal.temperature_coeff});
			omul_s2 <= dt_s1 * $signed({1'b0, cal.offset_temp_coeff});
			smul_s2 <= dt_s1 * $signed({1'b0, cal.sensitivity_temp_coeff});
			dtsq_s2 <= dt_s1 * dt_s1;
		end
	end

	// a is TEMP - 2000 before the second-order term
	assign a_c       = tmul_s2[ShiftTemp+AW-1:ShiftTemp];
	assign off_base  = $signed({3'b0, cal.pressure_offset, 16'b0});
	assign sens_base = $signed({3'b0, cal.pressure_sensitivity, 15'b0});

	always_ff @(posedge clk) begin
		if (en[2]) begin
			lin_s3.d1        <= d1_s2;
			lin_s3.a         <= a_c;
			lin_s3.b         <= $signed({a_c[AW-1], a_c}) + ColdOffset;
			lin_s3.cold      <= a_c[AW-1];
			lin_s3.very_cold <= a_c < ColdLimit;
			lin_s3.t2        <= dtsq_s2[ShiftT2+T2W-1:ShiftT2];
			lin_s3.off       <= off_base + $signed(omul_s2[ProdW-1:ShiftOff]);
			lin_s3.sens      <= sens_base + $signed(smul_s2[ProdW-1:ShiftSens]);
		end
	end

	assign lin = lin_s3;

endmodule

// File: design/bpc_corr.sv
// Stages 4-6: second-order correction of temperature, offset and sensitivity.
module bpc_corr (
	input  logic          clk,
	input  logic [2:0]    en,
	input  bpc_pkg::lin_t lin,
	output bpc_pkg::corr_t corr
);
	import bpc_pkg::*;

	// stage 4
	logic [RawW-1:0]         d1_s4;
	logic signed [AW-1:0]    a_s4;
	logic                    cold_s4;
	logic                    vcold_s4;
	logic [T2W-1:0]          t2_s4;
	logic signed [OffW-1:0]  off_s4;
	logic signed [SensW-1:0] sens_s4;
	logic [SqW-1:0]          asq_s4;
	logic [SqW-1:0]          bsq_s4;
	// stage 5
	logic [RawW-1:0]         d1_s5;
	logic signed [TempW-1:0] temp_s5;
	logic signed [OffW-1:0]  off_s5;
	logic signed [SensW-1:0] sens_s5;
	logic [Off2W-1:0]        off2_s5;
	logic [Sens2W-1:0]       sens2_s5;
	// stage 6
	corr_t                   corr_s6;

	logic signed [2*AW-1:0]  asq_full;
	logic signed [2*BW-1:0]  bsq_full;
	logic [36:0]             asq5;
	logic [37:0]             bsq7;
	logic [37:0]             bsq11;
	logic [Off2W-1:0]        off2_c;
	logic [Sens2W-1:0]       sens2_c;
	logic signed [19:0]      temp_full;
	logic signed [TempW-1:0] temp_sat;

	assign asq_full = lin.a * lin.a;
	assign bsq_full = lin.b * lin.b;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			d1_s4    <= lin.d1;
			a_s4     <= lin.a;
			cold_s4  <= lin.cold;
			vcold_s4 <= lin.very_cold;
			t2_s4    <= lin.t2;
			off_s4   <= lin.off;
			sens_s4  <= lin.sens;
			asq_s4   <= asq_full[SqW-1:0];
			bsq_s4   <= bsq_full[SqW-1:0];
		end
	end

	assign asq5  = {asq_s4, 2'b00} + {2'b00, asq_s4};
	assign bsq7  = {bsq_s4, 3'b000} - {3'b000, bsq_s4};
	assign bsq11 = {bsq_s4, 3'b000} + {2'b00, bsq_s4, 1'b0} + {3'b000, bsq_s4};

	always_comb begin
		off2_c  = '0;
		sens2_c = '0;
		if (cold_s4) begin
			off2_c  = {2'b00, asq5[36:1]};
			sens2_c = {2'b00, asq5[36:2]};
		end
		if (vcold_s4) begin
			off2_c  = off2_c + bsq7;
			sens2_c = sens2_c + bsq11[Sens2W:1];
		end
	end

	assign temp_full = $signed({{2{a_s4[AW-1]}}, a_s4}) + TempRef
		- $signed({3'b000, (cold_s4 ? t2_s4 : {T2W{1'b0}})});

	always_comb begin
		if (temp_full < -20'sd32768) begin
			temp_sat = 16'sh8000;
		end else if (temp_full > 20'sd32767) begin
			temp_sat = 16'sh7fff;
		end else begin
			temp_sat = temp_full[TempW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			d1_s5    <= d1_s4;
			temp_s5  <= temp_sat;
			off_s5   <= off_s4;
			sens_s5  <= sens_s4;
			off2_s5  <= off2_c;
			sens2_s5 <= sens2_c;
		end
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			corr_s6.d1     <= d1_s5;
			corr_s6.temp   <= temp_s5;
			corr_s6.off_c  <= $signed({{(OffCW-OffW){off_s5[OffW-1]}}, off_s5})
				- $signed({1'b0, off2_s5});
			corr_s6.sens_c <= $signed({{(SensCW-SensW){sens_s5[SensW-1]}}, sens_s5})
				- $signed({1'b0, sens2_s5});
		end
	end

	assign corr = corr_s6;

endmodule

// File: design/bpc_press.sv
// Stages 7-9: split pressure product, offset subtraction and output clamping.
module bpc_press (
	input  logic                            clk,
	input  logic [2:0]                      en,
	input  bpc_pkg::corr_t                  corr,
	output logic signed [bpc_pkg::TempW-1:0] temperature_centideg,
	output logic [bpc_pkg::PressW-1:0]       pressure_centimbar
);
	import bpc_pkg::*;

	localparam int HiW  = SensCW - SensSplit;
	localparam int PlW  = RawW + SensSplit;
	localparam int PhW  = RawW + 1 + HiW;
	localparam int SumW = PhW + SensSplit;
	localparam int PscW = SumW - ShiftPress;
	localparam int DifW = PscW + 1;
	localparam int PqW  = DifW - ShiftFinal;

	// stage 7
	logic [PlW-1:0]          pplo_s7;
	logic signed [PhW-1:0]   pphi_s7;
	logic signed [OffCW-1:0] off_s7;
	logic signed [TempW-1:0] temp_s7;
	// stage 8
	logic signed [PscW-1:0]  psc_s8;
	logic signed [OffCW-1:0] off_s8;
	logic signed [TempW-1:0] temp_s8;
	// stage 9
	logic [PressW-1:0]       press_s9;
	logic signed [TempW-1:0] temp_s9;

	logic signed [SumW-1:0]  sum_c;
	logic signed [DifW-1:0]  dif_c;
	logic signed [PqW-1:0]   pq_c;
	logic [PressW-1:0]       press_c;

	// d1 * sens as two partial products over the low and high halves of sens
	always_ff @(posedge clk) begin
		if (en[0]) begin
			pplo_s7 <= corr.d1 * corr.sens_c[SensSplit-1:0];
			pphi_s7 <= $signed({1'b0, corr.d1}) * $signed(corr.sens_c[SensCW-1:SensSplit]);
			off_s7  <= corr.off_c;
			temp_s7 <= corr.temp;
		end
	end

	assign sum_c = $signed({pphi_s7, {SensSplit{1'b0}}})
		+ $signed({{(SumW-PlW){1'b0}}, pplo_s7});

	always_ff @(posedge clk) begin
		if (en[1]) begin
			psc_s8  <= sum_c[SumW-1:ShiftPress];
			off_s8  <= off_s7;
			temp_s8 <= temp_s7;
		end
	end

	assign dif_c = $signed({psc_s8[PscW-1], psc_s8})
		- $signed({{(DifW-OffCW){off_s8[OffCW-1]}}, off_s8});
	assign pq_c  = dif_c[DifW-1:ShiftFinal];

	always_comb begin
		if (pq_c[PqW-1]) begin
			press_c = '0;
		end else if (|pq_c[PqW-2:PressW]) begin
			press_c = '1;
		end else begin
			press_c = pq_c[PressW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			press_s9 <= press_c;
			temp_s9  <= temp_s8;
		end
	end

	assign temperature_centideg = temp_s9;
	assign pressure_centimbar   = press_s9;

endmodule

// File: design/baro_pressure_temp_compensation.sv
// Top level: second-order barometric pressure and temperature compensation.
//
//  channel   direction  handshake                     payload
//  sample    in         sample_valid / sample_stall   raw_pressure, raw_temperature
//  result    out        result_valid / result_stall   temperature_centideg, pressure_centimbar
//  config    in         APB psel/penable/pwrite       six 16-bit calibration words at 4*i
//
// One request per cycle when nothing stalls, through nine register stages. The depth is set
// by the multiplier stages: the four first-order products, the two squares and the split
// 24x38 pressure product. A stalled result holds only the stages behind it until an empty
// stage is reached.
// Reset clears the valid bits and the calibration words to zero.
module baro_pressure_temp_compensation (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             sample_valid,
	output logic                             sample_stall,
	input  logic [bpc_pkg::RawW-1:0]         raw_pressure,
	input  logic [bpc_pkg::RawW-1:0]         raw_temperature,
	output logic                             result_valid,
	input  logic                             result_stall,
	output logic signed [bpc_pkg::TempW-1:0] temperature_centideg,
	output logic [bpc_pkg::PressW-1:0]       pressure_centimbar,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [bpc_pkg::AddrW-1:0]        paddr,
	input  logic [bpc_pkg::DataW-1:0]        pwdata,
	output logic [bpc_pkg::DataW-1:0]        prdata,
	output logic                             pready
);
	import bpc_pkg::*;

	cal_t       cal;
	stage_vec_t en;
	lin_t       lin;
	corr_t      corr;

	assign pready = 1'b1;

	bpc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cal     (cal)
	);

	bpc_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.result_stall (result_stall),
		.en           (en),
		.sample_stall (sample_stall),
		.result_valid (result_valid)
	);

	bpc_lin u_lin (
		.clk             (clk),
		.en              (en[2:0]),
		.cal             (cal),
		.raw_pressure    (raw_pressure),
		.raw_temperature (raw_temperature),
		.lin             (lin)
	);

	bpc_corr u_corr (
		.clk  (clk),
		.en   (en[5:3]),
		.lin  (lin),
		.corr (corr)
	);

	bpc_press u_press (
		.clk                  (clk),
		.en                   (en[8:6]),
		.corr                 (corr),
		.temperature_centideg (temperature_centideg),
		.pressure_centimbar   (pressure_centimbar)
	);

endmodule

// File: design/bpc_checker.sv
// Port-level checks for the compensation block, bound to the top level.
module bpc_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             sample_valid,
	input logic                             sample_stall,
	input logic [bpc_pkg::RawW-1:0]         raw_pressure,
	input logic [bpc_pkg::RawW-1:0]         raw_temperature,
	input logic                             result_valid,
	input logic                             result_stall,
	input logic signed [bpc_pkg::TempW-1:0] temperature_centideg,
	input logic [bpc_pkg::PressW-1:0]       pressure_centimbar,
	input logic                             psel,
	input logic                             penable,
	input logic                             pwrite,
	input logic [bpc_pkg::AddrW-1:0]        paddr,
	input logic [bpc_pkg::DataW-1:0]        pwdata,
	input logic [bpc_pkg::DataW-1:0]        prdata,
	input logic                             pready
);
	import bpc_pkg::*;

	logic cfg_wr;
	assign cfg_wr = psel && penable && pwrite && pready;

	// a refused request is held unchanged by the sender
	a_sample_hold: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && sample_stall |=> sample_valid
			&& $stable(raw_pressure) && $stable(raw_temperature))
		else $error("request changed while stalled");

	// a held result keeps its value
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid
			&& $stable(temperature_centideg) && $stable(pressure_centimbar))
		else $error("result changed while stalled");

	// requests are refused only when every stage is full and the result is held
	a_stall_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		sample_stall |-> result_valid && result_stall)
		else $error("request refused with room in the pipeline");

	// a written calibration word reads back
	a_cfg_readback: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wr && paddr[4:2] <= RegTempCoeff
			|=> ($stable(paddr) |-> prdata == {16'b0, $past(pwdata[15:0])}))
		else $error("calibration word did not read back");

	// unmapped addresses read as zero
	a_cfg_unmapped: assert property (@(posedge clk) disable iff (!arst_n)
		paddr[4:2] > RegTempCoeff |-> prdata == '0)
		else $error("unmapped register read non-zero");

endmodule

bind baro_pressure_temp_compensation bpc_checker u_bpc_checker (.*);
